// File: rtl/core/arc_pkg.sv
// Shared types and constants for the address result cache.
`timescale 1ns / 1ps

package arc_pkg;

    localparam int unsigned CACHE_DEPTH_DEF = 16;
    localparam int unsigned WORD_W          = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SELECT,
        ST_READ,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic match_en;
        logic sel_en;
        logic rd_capture;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_sts;

endpackage

// File: rtl/core/arc_ctrl.sv
// Sequencing state machine for the address result cache.
`timescale 1ns / 1ps

module arc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  arc_pkg::t_sts i_sts,
    output arc_pkg::t_cmd o_cmd
);

    arc_pkg::t_state r_state;
    arc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            arc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = arc_pkg::ST_MATCH;
                end
            end
            arc_pkg::ST_MATCH: begin
                o_cmd.match_en = 1'b1;
                n_state        = arc_pkg::ST_SELECT;
            end
            arc_pkg::ST_SELECT: begin
                o_cmd.sel_en = 1'b1;
                n_state      = i_sts.hit ? arc_pkg::ST_READ : arc_pkg::ST_OUTPUT;
            end
            arc_pkg::ST_READ: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = arc_pkg::ST_OUTPUT;
            end
            arc_pkg::ST_OUTPUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = arc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != arc_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == arc_pkg::ST_MATCH))
        else $error("accepted word did not start a lookup");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("pending result overwritten");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == arc_pkg::ST_OUTPUT))
        else $error("result appeared outside output step");

    a_hit_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == arc_pkg::ST_SELECT && i_sts.hit) |=> (r_state == arc_pkg::ST_READ))
        else $error("hit did not read value store");
`endif

endmodule

// File: rtl/core/arc_dpath.sv
// Key compare, value store, replacement pointer and result registers.
`timescale 1ns / 1ps

module arc_dpath #(
    parameter int unsigned CACHE_DEPTH = arc_pkg::CACHE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  arc_pkg::t_cmd               i_cmd,
    output arc_pkg::t_sts               o_sts,
    input  logic [arc_pkg::WORD_W-1:0]  i_addr,
    input  logic [arc_pkg::WORD_W-1:0]  i_fill_data,
    output logic                        o_hit,
    output logic [arc_pkg::WORD_W-1:0]  o_data
);

    localparam int unsigned IDX_W = $clog2(CACHE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);

    logic [arc_pkg::WORD_W-1:0] r_addr;
    logic [arc_pkg::WORD_W-1:0] r_fill;
    logic [arc_pkg::WORD_W-1:0] r_key [CACHE_DEPTH];
    logic [arc_pkg::WORD_W-1:0] r_mem [CACHE_DEPTH];
    logic [arc_pkg::WORD_W-1:0] r_mem_q;
    logic [CACHE_DEPTH-1:0]     r_match;
    logic [CACHE_DEPTH-1:0]     n_match;
    logic [IDX_W-1:0]           r_ptr;
    logic [IDX_W-1:0]           n_ptr;
    logic [IDX_W-1:0]           hit_idx;
    logic                       any_hit;
    logic                       r_res_hit;
    logic [arc_pkg::WORD_W-1:0] r_res_data;
    logic                       r_out_hit;
    logic [arc_pkg::WORD_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_addr <= i_addr;
            r_fill <= i_fill_data;
        end
    end

    always_comb begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            n_match[i] = (r_key[i] == r_addr) && (r_addr != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match_en) begin
            r_match <= n_match;
        end
    end

    assign any_hit = |r_match;

    // lowest matching entry wins
    always_comb begin
        hit_idx = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (any_hit) begin
            n_ptr = (hit_idx == LAST_IDX) ? '0 : hit_idx + 1'b1;
        end else begin
            n_ptr = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cmd.sel_en) begin
            r_ptr <= n_ptr;
            if (!any_hit) begin
                r_key[r_ptr] <= r_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_en && !any_hit) begin
            r_mem[r_ptr] <= r_fill;
        end
        r_mem_q <= r_mem[hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_en) begin
            r_res_hit <= any_hit;
            if (!any_hit) begin
                r_res_data <= r_fill;
            end
        end else if (i_cmd.rd_capture) begin
            r_res_data <= r_mem_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_hit  <= r_res_hit;
            r_out_data <= r_res_data;
        end
    end

    assign o_sts.hit = any_hit;
    assign o_hit     = r_out_hit;
    assign o_data    = r_out_data;

endmodule

// File: rtl/core/address_result_cache.sv
// Address result cache: fully associative, circular victim pointer.
// A word taken in idle passes the match and select states, the
// value-read state on a hit only, and the output state, which loads
// the result register. A new word is taken only back in idle.
// The output register lets a finished word wait while the next is taken.
// Reset (synchronous, active low) empties all keys and zeroes the pointer.
`timescale 1ns / 1ps

module address_result_cache #(
    parameter int unsigned CACHE_DEPTH = arc_pkg::CACHE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [arc_pkg::WORD_W-1:0] i_addr,
    input  logic [arc_pkg::WORD_W-1:0] i_fill_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_hit,
    output logic [arc_pkg::WORD_W-1:0] o_data
);

    arc_pkg::t_cmd cmd;
    arc_pkg::t_sts sts;

    arc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    arc_dpath #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_addr      (i_addr),
        .i_fill_data (i_fill_data),
        .o_hit       (o_hit),
        .o_data      (o_data)
    );

endmodule
